/* src/assert_macros.svh */
// assertion macros for the salsa20 keystream block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

/* src/s20_pkg.sv */
// shared types, constants and rotate function for the salsa20 keystream block
// no dependencies
package s20_pkg;
	localparam int DoubleRounds = 10;
	localparam logic [4:0] RoundsLast = 5'(2 * DoubleRounds - 1);
	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;
	localparam logic [1:0] RegKey0 = 2'd0;
	localparam logic [1:0] RegKey1 = 2'd1;
	localparam logic [1:0] RegKey2 = 2'd2;
	localparam logic [1:0] RegKey3 = 2'd3;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        new_block;
		logic        first;
		logic [63:0] nonce;
	} cmd_t;

	typedef logic [15:0][31:0] state_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		rotl = (v << s) | (v >> (32 - s));
	endfunction
endpackage

/* src/s20_front.sv */
// front end: accepts words, saturates counts, marks block starts
// depends on s20_pkg
module s20_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [63:0]    nonce_in,
	input  logic [63:0]    data_in,
	input  logic [3:0]     byte_count,
	input  logic           first_word,
	output logic           q_valid,
	input  logic           q_ready,
	output s20_pkg::cmd_t  q_cmd
);
	logic [2:0] pos_q;
	logic [1:0] cnt_q;
	logic wr_q, rd_q;
	s20_pkg::cmd_t fifo_q [2];
	s20_pkg::cmd_t cmd;
	logic acc, pop;

	assign in_ready = (cnt_q != 2'd2);
	assign acc = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = fifo_q[rd_q];

	always_comb begin
		cmd.data = data_in;
		cmd.count = (byte_count > 4'd8) ? 4'd8 : byte_count;
		cmd.first = first_word;
		cmd.nonce = nonce_in;
		cmd.new_block = first_word || (pos_q == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= 3'd0;
			cnt_q <= 2'd0;
			wr_q <= 1'b0;
			rd_q <= 1'b0;
		end else begin
			if (acc) begin
				pos_q <= first_word ? 3'd1 : pos_q + 3'd1;
				wr_q <= ~wr_q;
			end
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (acc) fifo_q[wr_q] <= cmd;
	end
endmodule

/* src/s20_core.sv */
// back end: one quarter-round per cycle block generator plus xor
// depends on s20_pkg
module s20_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [255:0]   key,
	input  logic           q_valid,
	output logic           q_ready,
	input  s20_pkg::cmd_t  q_cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [63:0]    data_out,
	output logic [3:0]     out_count
);
	typedef enum logic [3:0] {
		IDLE  = 4'b0001,
		ROUND = 4'b0010,
		FIN   = 4'b0100,
		EMIT  = 4'b1000
	} st_t;

	st_t st_q;
	s20_pkg::state_t w_q, init_q;
	logic [63:0] ks_q [8];
	logic [63:0] nonce_q, ctr_q;
	logic [2:0] pos_q;
	logic [4:0] rnd_q;
	logic [1:0] qr_q;
	logic [2:0] fin_q;
	s20_pkg::cmd_t cur_q;
	logic out_free;
	logic [63:0] mask;
	s20_pkg::state_t w_n;
	logic [3:0] ia, ib, ic, id;
	logic [31:0] va, vb, vc, vd;
	s20_pkg::state_t init_n;
	logic [63:0] nonce_n, ctr_n;

	assign out_free = !out_valid || out_ready;
	assign q_ready = (st_q == IDLE) && out_free;

	always_comb begin
		ia = 4'd0; ib = 4'd0; ic = 4'd0; id = 4'd0;
		if (!rnd_q[0]) begin
			unique case (qr_q)
				2'd0: begin ia = 4'd0;  ib = 4'd4;  ic = 4'd8;  id = 4'd12; end
				2'd1: begin ia = 4'd5;  ib = 4'd9;  ic = 4'd13; id = 4'd1;  end
				2'd2: begin ia = 4'd10; ib = 4'd14; ic = 4'd2;  id = 4'd6;  end
				default: begin ia = 4'd15; ib = 4'd3; ic = 4'd7; id = 4'd11; end
			endcase
		end else begin
			unique case (qr_q)
				2'd0: begin ia = 4'd0;  ib = 4'd1;  ic = 4'd2;  id = 4'd3;  end
				2'd1: begin ia = 4'd5;  ib = 4'd6;  ic = 4'd7;  id = 4'd4;  end
				2'd2: begin ia = 4'd10; ib = 4'd11; ic = 4'd8;  id = 4'd9;  end
				default: begin ia = 4'd15; ib = 4'd12; ic = 4'd13; id = 4'd14; end
			endcase
		end
		vb = w_q[ib] ^ s20_pkg::rotl(w_q[ia] + w_q[id], 7);
		vc = w_q[ic] ^ s20_pkg::rotl(vb + w_q[ia], 9);
		vd = w_q[id] ^ s20_pkg::rotl(vc + vb, 13);
		va = w_q[ia] ^ s20_pkg::rotl(vd + vc, 18);
		w_n = w_q;
		w_n[ia] = va;
		w_n[ib] = vb;
		w_n[ic] = vc;
		w_n[id] = vd;
	end

	always_comb begin
		nonce_n = q_cmd.first ? q_cmd.nonce : nonce_q;
		ctr_n = q_cmd.first ? 64'd0 : ctr_q;
		init_n[0] = s20_pkg::Sigma0;
		init_n[5] = s20_pkg::Sigma1;
		init_n[10] = s20_pkg::Sigma2;
		init_n[15] = s20_pkg::Sigma3;
		init_n[1] = key[31:0];
		init_n[2] = key[63:32];
		init_n[3] = key[95:64];
		init_n[4] = key[127:96];
		init_n[11] = key[159:128];
		init_n[12] = key[191:160];
		init_n[13] = key[223:192];
		init_n[14] = key[255:224];
		init_n[6] = nonce_n[31:0];
		init_n[7] = nonce_n[63:32];
		init_n[8] = ctr_n[31:0];
		init_n[9] = ctr_n[63:32];
	end

	always_comb begin
		if (cur_q.count >= 4'd8) mask = '1;
		else mask = (64'd1 << {cur_q.count[2:0], 3'b000}) - 64'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			nonce_q <= 64'd0;
			ctr_q <= 64'd0;
			pos_q <= 3'd0;
			rnd_q <= 5'd0;
			qr_q <= 2'd0;
			fin_q <= 3'd0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (st_q)
				IDLE: begin
					if (q_valid && out_free) begin
						if (q_cmd.new_block) begin
							nonce_q <= nonce_n;
							ctr_q <= ctr_n + 64'd1;
							pos_q <= 3'd0;
							rnd_q <= 5'd0;
							qr_q <= 2'd0;
							st_q <= ROUND;
						end else begin
							st_q <= EMIT;
						end
					end
				end
				ROUND: begin
					qr_q <= qr_q + 2'd1;
					if (qr_q == 2'd3) begin
						rnd_q <= rnd_q + 5'd1;
						if (rnd_q == s20_pkg::RoundsLast) begin
							fin_q <= 3'd0;
							st_q <= FIN;
						end
					end
				end
				FIN: begin
					fin_q <= fin_q + 3'd1;
					if (fin_q == 3'd7) st_q <= EMIT;
				end
				EMIT: begin
					out_valid <= 1'b1;
					pos_q <= pos_q + 3'd1;
					st_q <= IDLE;
				end
				default: st_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == IDLE && q_valid && out_free) begin
			cur_q <= q_cmd;
			if (q_cmd.new_block) begin
				init_q <= init_n;
				w_q <= init_n;
			end
		end
		if (st_q == ROUND) w_q <= w_n;
		if (st_q == FIN) begin
			ks_q[fin_q] <= {w_q[{fin_q, 1'b1}] + init_q[{fin_q, 1'b1}],
				w_q[{fin_q, 1'b0}] + init_q[{fin_q, 1'b0}]};
		end
		if (st_q == EMIT) begin
			data_out <= (cur_q.data ^ ks_q[pos_q]) & mask;
			out_count <= cur_q.count;
		end
	end
endmodule

/* src/salsa20_keystream_xor.sv */
// Salsa20/20 keystream xor, top level with key registers
// depends on s20_pkg, s20_front, s20_core, assert_macros.svh
// Each word passes through the back end's IDLE and EMIT states; a word that opens a 64-byte
// block first runs the ROUND state (one column or row quarter-round per cycle, ten double
// rounds) and then FIN, which adds the input state. A two-entry queue lets the front
// accept while a block is made.
`include "assert_macros.svh"
module salsa20_keystream_xor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] nonce_in,
	input  logic [63:0] data_in,
	input  logic [3:0]  byte_count,
	input  logic        first_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] data_out,
	output logic [3:0]  out_count
);
	logic [255:0] key_q;
	logic q_valid, q_ready;
	s20_pkg::cmd_t q_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				s20_pkg::RegKey0: key_q[63:0] <= cfg_data;
				s20_pkg::RegKey1: key_q[127:64] <= cfg_data;
				s20_pkg::RegKey2: key_q[191:128] <= cfg_data;
				s20_pkg::RegKey3: key_q[255:192] <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	s20_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .nonce_in, .data_in, .byte_count,
		.first_word, .q_valid, .q_ready, .q_cmd
	);

	s20_core u_core (
		.clk, .arst_n, .key(key_q), .q_valid, .q_ready, .q_cmd,
		.out_valid, .out_ready, .data_out, .out_count
	);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(data_out))
	`ASSERT_IMPLIES(a_count_range, clk, arst_n, out_valid, out_count <= 4'd8)
	`ASSERT_IMPLIES(a_pop_free, clk, arst_n, q_valid && q_ready, !out_valid || out_ready)
endmodule
